// ===== src/slt_pkg.sv =====
// slt_pkg: item and result types, operation and status codes
// for the sorted list table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slt_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] item_value;
    } slt_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] position;
        logic [5:0] entry_count;
    } slt_result_t;

endpackage

`default_nettype wire

// ===== src/sorted_list_table.sv =====
// Sorted list table: keeps up to CAPACITY signed 32-bit values in ascending order in one
// on-chip memory (duplicates allowed) and serves insert, search and remove items, one
// result item each. An item is taken only while the sequencer is idle; the result sits in
// an output register, so the next item can be taken while it waits. Per item: the item is
// taken, the lower bound is found by binary search with one memory read per probe, search
// and remove add the equality read, insert and remove read then write every entry moved
// (through the single memory port pair), insert adds the final write, and the result is
// handed to the output register. A refused item (full, empty, unknown code) goes straight
// to the result.
// The memory needs no clearing after reset: only entries below the count are read.
// Depends on slt_pkg, slt_ctrl, slt_mem.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_table #(
    parameter int CAPACITY = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire slt_pkg::slt_item_t   item_data,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output slt_pkg::slt_result_t      result_data
);

    import slt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic          busy;
    logic          res_valid;
    slt_result_t   res_data;
    logic          slot_free;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    logic          result_valid_reg;
    slt_result_t   result_data_reg;

    assign slot_free  = !result_valid_reg || !result_stall;
    assign item_stall = busy;

    slt_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_data  (item_data),
        .busy       (busy),
        .res_valid  (res_valid),
        .res_data   (res_data),
        .res_ready  (slot_free),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    slt_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            result_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && res_valid)
        begin
            result_data_reg <= res_data;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

endmodule

`default_nettype wire

// ===== src/slt_mem.sv =====
// slt_mem: single-clock table memory, one write and one read port,
// read data registered. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module slt_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [31:0]   wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [31:0]   rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/slt_ctrl.sv =====
// slt_ctrl: operation sequencer: binary search for the lower bound,
// entry shifting for insert and remove. Uses slt_pkg, drives slt_mem.
`timescale 1ns / 1ps
`default_nettype none

module slt_ctrl #(
    parameter int CAPACITY = 32,
    parameter int AW       = 5
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire slt_pkg::slt_item_t item_data,
    output logic                   busy,
    output logic                   res_valid,
    output slt_pkg::slt_result_t   res_data,
    input  wire logic              res_ready,
    output logic                   rd_en,
    output logic      [AW-1:0]     rd_addr,
    input  wire logic [31:0]       rd_data,
    output logic                   wr_en,
    output logic      [AW-1:0]     wr_addr,
    output logic      [31:0]       wr_data
);

    import slt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BS,
        S_BS_WAIT,
        S_CHK_WAIT,
        S_SH_RD,
        S_SH_WR,
        S_INS_PUT,
        S_DONE
    } state_t;

    state_t             state_reg,  state_next;
    logic [1:0]         op_reg,     op_next;
    logic signed [31:0] val_reg,    val_next;
    logic [CW-1:0]      lo_reg,     lo_next;
    logic [CW-1:0]      hi_reg,     hi_next;
    logic [CW-1:0]      count_reg,  count_next;
    logic [AW-1:0]      mid_reg,    mid_next;
    logic [AW-1:0]      ptr_reg,    ptr_next;
    logic [AW-1:0]      pos_reg,    pos_next;
    logic [1:0]         status_reg, status_next;

    logic [CW:0]        bound_sum;
    logic [AW-1:0]      mid_calc;
    logic [CW-1:0]      last_idx;

    assign bound_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc  = AW'(bound_sum >> 1);
    assign last_idx  = count_reg - CW'(1);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        count_next  = count_reg;
        mid_next    = mid_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = val_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op_next  = item_data.operation;
                    val_next = item_data.item_value;
                    lo_next  = '0;
                    hi_next  = count_reg;
                    pos_next = '0;
                    priority if (item_data.operation == OP_INSERT &&
                                 count_reg == CW'(CAPACITY))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else if (item_data.operation == OP_REMOVE && count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_DONE;
                    end
                    else if (item_data.operation != OP_INSERT &&
                             item_data.operation != OP_SEARCH &&
                             item_data.operation != OP_REMOVE)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_BS;
                    end
                end
            end

            S_BS:
            begin
                priority if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = mid_calc;
                    mid_next   = mid_calc;
                    state_next = S_BS_WAIT;
                end
                else if (op_reg == OP_INSERT)
                begin
                    // lower bound at the end needs no shifting
                    if (lo_reg == count_reg)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        ptr_next   = AW'(last_idx);
                        state_next = S_SH_RD;
                    end
                end
                else if (lo_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(lo_reg);
                    state_next = S_CHK_WAIT;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
            end

            S_BS_WAIT:
            begin
                if ($signed(rd_data) < val_reg)
                begin
                    lo_next = CW'(mid_reg) + CW'(1);
                end
                else
                begin
                    hi_next = CW'(mid_reg);
                end
                state_next = S_BS;
            end

            S_CHK_WAIT:
            begin
                priority if (rd_data != val_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else if (op_reg == OP_SEARCH || lo_reg == last_idx)
                begin
                    // search hit, or removal of the last entry
                    if (op_reg == OP_REMOVE)
                    begin
                        count_next = last_idx;
                    end
                    status_next = ST_OK;
                    pos_next    = AW'(lo_reg);
                    state_next  = S_DONE;
                end
                else
                begin
                    ptr_next   = AW'(lo_reg) + AW'(1);
                    state_next = S_SH_RD;
                end
            end

            S_SH_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = ptr_reg;
                state_next = S_SH_WR;
            end

            S_SH_WR:
            begin
                wr_en   = 1'b1;
                wr_data = rd_data;
                if (op_reg == OP_INSERT)
                begin
                    // move up, walking from the top down to the lower bound
                    wr_addr = ptr_reg + AW'(1);
                    if (CW'(ptr_reg) == lo_reg)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg - AW'(1);
                        state_next = S_SH_RD;
                    end
                end
                else
                begin
                    // move down, walking from the hit up to the top
                    wr_addr = ptr_reg - AW'(1);
                    if (CW'(ptr_reg) == last_idx)
                    begin
                        count_next  = last_idx;
                        status_next = ST_OK;
                        pos_next    = AW'(lo_reg);
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + AW'(1);
                        state_next = S_SH_RD;
                    end
                end
            end

            S_INS_PUT:
            begin
                wr_en       = 1'b1;
                wr_addr     = AW'(lo_reg);
                wr_data     = val_reg;
                count_next  = count_reg + CW'(1);
                status_next = ST_OK;
                pos_next    = AW'(lo_reg);
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            op_reg     <= OP_INSERT;
            val_reg    <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            mid_reg    <= '0;
            ptr_reg    <= '0;
            pos_reg    <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            op_reg     <= op_next;
            val_reg    <= val_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            mid_reg    <= mid_next;
            ptr_reg    <= ptr_next;
            pos_reg    <= pos_next;
            status_reg <= status_next;
        end
    end

    assign busy                 = (state_reg != S_IDLE);
    assign res_valid            = (state_reg == S_DONE);
    assign res_data.status      = status_reg;
    assign res_data.position    = 5'(pos_reg);
    assign res_data.entry_count = 6'(count_reg);

endmodule

`default_nettype wire

// ===== src/slt_checker.sv =====
// slt_checker: port-level assertions for sorted_list_table, and the bind
// that attaches them. Uses slt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slt_checker #(
    parameter int CAPACITY = 32
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 item_valid,
    input wire logic                 item_stall,
    input wire logic                 result_valid,
    input wire logic                 result_stall,
    input wire slt_pkg::slt_result_t result_data
);

    import slt_pkg::*;

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("stalled result changed or dropped");

    // full refusal only when the table is at capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status == ST_FULL |->
            result_data.entry_count == 6'(CAPACITY) && result_data.position == 5'd0)
        else $error("full status with table not full");

    // empty status only when nothing is stored
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status == ST_EMPTY |->
            result_data.entry_count == 6'd0 && result_data.position == 5'd0)
        else $error("empty status with entries stored");

    // a miss reports position zero
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status == ST_NOT_FOUND |->
            result_data.position == 5'd0)
        else $error("miss with nonzero position");

    // an accepted item is not followed by a result in the very next cycle
    // unless one was already waiting
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && !result_valid |=> !result_valid)
        else $error("result appeared without sequencer latency");

endmodule

bind sorted_list_table slt_checker #(
    .CAPACITY (CAPACITY)
) u_slt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for sorted_list_table, with its own table predictor,
// random insert/search/remove traffic and random idling on both sides.
// Depends on slt_pkg and sorted_list_table.
`timescale 1ns / 1ps

module tb_top;
    import slt_pkg::*;

    localparam int          TABLE_CAP  = 32;
    localparam logic [1:0]  OP_UNUSED  = 2'd3;
    localparam int          HOLD_START = 150;
    localparam int          HOLD_LEN   = 400;
    localparam int          MAX_REPORT = 10;

    typedef struct {
        slt_item_t item;
        bit        drain;
    } queued_item_t;

    typedef struct {
        slt_item_t   item;
        slt_result_t res;
    } table_answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    slt_item_t   item_data = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    slt_result_t result_data;

    queued_item_t  item_backlog[$];
    table_answer_t awaited_answers[$];

    logic signed [31:0] table_vals[TABLE_CAP];
    int table_len = 0;

    int  error_count = 0;
    int  answers_seen = 0;
    bit  item_taken = 1'b0;
    int  tx_gap = 0;
    int  tx_calm = 0;
    int  rx_gap = 0;
    int  rx_calm = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    sorted_list_table #(.CAPACITY(TABLE_CAP)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        #4_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // mostly no gap, some short, a few long; now and then a calm stretch with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // applies one operation to the local copy of the table
    task automatic table_apply(input slt_item_t it, output slt_result_t res);
        logic signed [31:0] v;
        int idx;
        int k;
        v = it.item_value;
        res.status   = ST_NOT_FOUND;
        res.position = '0;
        idx = 0;
        while (idx < table_len && table_vals[idx] < v)
            idx++;
        case (it.operation)
            OP_INSERT:
            begin
                if (table_len >= TABLE_CAP)
                    res.status = ST_FULL;
                else
                begin
                    for (k = table_len; k > idx; k--)
                        table_vals[k] = table_vals[k - 1];
                    table_vals[idx] = v;
                    table_len++;
                    res.status   = ST_OK;
                    res.position = idx[4:0];
                end
            end
            OP_SEARCH:
            begin
                if (idx < table_len && table_vals[idx] == v)
                begin
                    res.status   = ST_OK;
                    res.position = idx[4:0];
                end
            end
            OP_REMOVE:
            begin
                if (table_len == 0)
                    res.status = ST_EMPTY;
                else if (idx < table_len && table_vals[idx] == v)
                begin
                    for (k = idx; k < table_len - 1; k++)
                        table_vals[k] = table_vals[k + 1];
                    table_len--;
                    res.status   = ST_OK;
                    res.position = idx[4:0];
                end
            end
            default:
            begin
            end
        endcase
        res.entry_count = table_len[5:0];
    endtask

    // sender: new item or idle at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_taken)
            begin
                // stalled item stays put
            end
            else if (tx_gap > 0)
            begin
                item_valid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end
            else if (item_backlog.size() != 0 &&
                     !(item_backlog[0].drain && awaited_answers.size() != 0))
            begin
                item_data  <= item_backlog[0].item;
                item_valid <= 1'b1;
                void'(item_backlog.pop_front());
                tx_gap <= pick_gap(tx_calm);
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off once traffic is under way
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && answers_seen == HOLD_START)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // receiver: random stalls at the falling edge
    always @(negedge clk)
    begin
        if (rx_gap > 0)
        begin
            result_stall <= 1'b1;
            rx_gap <= rx_gap - 1;
        end
        else
        begin
            result_stall <= (hold_left != 0);
            rx_gap <= pick_gap(rx_calm);
        end
    end

    // monitor: predict on every accepted item, check every accepted result
    always @(posedge clk)
    begin
        table_answer_t ans;
        table_answer_t got;
        if (rst_n)
        begin
            item_taken <= item_valid && !item_stall;
            if (item_valid && !item_stall)
            begin
                ans.item = item_data;
                table_apply(item_data, ans.res);
                awaited_answers.push_back(ans);
            end
            if (result_valid && !result_stall)
            begin
                answers_seen <= answers_seen + 1;
                if (awaited_answers.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORT)
                        $display("unexpected result: status %0d pos %0d count %0d",
                                 result_data.status, result_data.position,
                                 result_data.entry_count);
                end
                else
                begin
                    got = awaited_answers.pop_front();
                    if (result_data.status !== got.res.status ||
                        result_data.position !== got.res.position ||
                        result_data.entry_count !== got.res.entry_count)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORT)
                            $display({"mismatch op %0d value %0d: expected status %0d ",
                                      "pos %0d count %0d, got status %0d pos %0d count %0d"},
                                     got.item.operation, got.item.item_value,
                                     got.res.status, got.res.position, got.res.entry_count,
                                     result_data.status, result_data.position,
                                     result_data.entry_count);
                    end
                end
            end
        end
    end

    task automatic queue_item(input logic [1:0] op, input logic signed [31:0] v,
                              input bit drain);
        queued_item_t q;
        q.item.operation  = op;
        q.item.item_value = v;
        q.drain = drain;
        item_backlog.push_back(q);
    endtask

    // small values so that searches and removes hit, plus extremes and raw words
    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $signed($urandom_range(0, 15)) - 8;
        if (r < 82)
        begin
            case ($urandom_range(0, 5))
                0: return 32'sh8000_0000;
                1: return 32'sh8000_0001;
                2: return 32'sh7FFF_FFFF;
                3: return 32'sh7FFF_FFFE;
                4: return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        return $urandom;
    endfunction

    // mode 0 grows the table, 1 shrinks it, 2 mixes
    function automatic logic [1:0] pick_op(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return OP_UNUSED;
        case (mode)
            0: return (r < 70) ? OP_INSERT : (r < 85) ? OP_SEARCH : OP_REMOVE;
            1: return (r < 20) ? OP_INSERT : (r < 35) ? OP_SEARCH : OP_REMOVE;
            default: return (r < 40) ? OP_INSERT : (r < 70) ? OP_SEARCH : OP_REMOVE;
        endcase
    endfunction

    initial
    begin
        int n;
        int mode;
        // empty table cases
        queue_item(OP_SEARCH, 32'sd0, 1'b0);
        queue_item(OP_REMOVE, 32'sd5, 1'b0);
        queue_item(OP_UNUSED, 32'sd0, 1'b0);
        // extremes and a duplicate going in front of its equal
        queue_item(OP_INSERT, 32'sd0, 1'b0);
        queue_item(OP_INSERT, 32'sh7FFF_FFFF, 1'b0);
        queue_item(OP_INSERT, 32'sh8000_0000, 1'b0);
        queue_item(OP_INSERT, 32'sd0, 1'b0);
        queue_item(OP_INSERT, -32'sd1, 1'b0);
        queue_item(OP_INSERT, 32'sd1, 1'b0);
        queue_item(OP_SEARCH, 32'sd0, 1'b0);
        // lower bound lands on a larger entry
        queue_item(OP_SEARCH, 32'sd5, 1'b0);
        queue_item(OP_SEARCH, 32'sh7FFF_FFFF, 1'b0);
        queue_item(OP_SEARCH, 32'sh8000_0000, 1'b0);
        queue_item(OP_SEARCH, 32'sd2, 1'b0);
        queue_item(OP_REMOVE, 32'sd7, 1'b0);
        queue_item(OP_UNUSED, -32'sd1, 1'b0);
        queue_item(OP_REMOVE, 32'sd0, 1'b0);
        queue_item(OP_REMOVE, 32'sh8000_0000, 1'b0);
        queue_item(OP_REMOVE, 32'sh7FFF_FFFF, 1'b0);
        queue_item(OP_SEARCH, 32'sd0, 1'b0);
        queue_item(OP_INSERT, 32'sh5555_5555, 1'b0);
        queue_item(OP_INSERT, 32'shAAAA_AAAA, 1'b0);

        mode = 0;
        for (n = 0; n < 928; n++)
        begin
            if (n % 116 == 0)
                mode = (n / 116) % 3;
            // one item waits until the block has answered everything
            queue_item(pick_op(mode), pick_value(), n == 500);
        end

        while (item_backlog.size() != 0 || item_valid)
            @(posedge clk);
        while (awaited_answers.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
